@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define CSK_ASSERT(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("csk assertion failed");

// clocked check, always on
`define CSK_ASSERT_ALWAYS(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("csk assertion failed");

`endif

@@ hdl/csk_pkg.sv @@
// ----------------------------------------------------------------------------
// csk_pkg
// shared constants and types of the keyed-record counting sort
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csk_pkg;

  localparam int MAX_RECORDS   = 64;
  localparam int KEY_BUCKETS   = 32;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int KEY_W      = 5;
  localparam int PAY_PORT_W = 32;
  localparam int CNT_W      = $clog2(MAX_RECORDS + 1);
  localparam int REC_AW     = $clog2(MAX_RECORDS);
  localparam int BKT_W      = $clog2(KEY_BUCKETS);
  localparam int REC_W      = KEY_W + PAYLOAD_WIDTH;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SUM,
    ST_PLACE,
    ST_EMIT
  } state_t;

  // one histogram access per cycle: a read, a write and a bulk clear
  typedef struct packed {
    logic             re;
    logic [BKT_W-1:0] raddr;
    logic             we;
    logic [BKT_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             clear;
  } hist_req_t;

endpackage

@@ hdl/csk_ram.sv @@
// ----------------------------------------------------------------------------
// csk_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/csk_hist.sv @@
// ----------------------------------------------------------------------------
// csk_hist
// key histogram: ram with per-bucket valid bits and write-to-read forwarding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csk_hist
  import csk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  hist_req_t        req,
  output logic [CNT_W-1:0] rdata
);

  logic [KEY_BUCKETS-1:0] valid;
  logic                   fwd_hit;
  logic [CNT_W-1:0]       fwd_data;
  logic [BKT_W-1:0]       raddr_q;
  logic [CNT_W-1:0]       ram_q;

  csk_ram #(
    .WIDTH (CNT_W),
    .DEPTH (KEY_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (req.clear) begin
        valid <= '0;
      end else if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      fwd_hit <= req.we && req.re && (req.waddr == req.raddr);
    end
    fwd_data <= req.wdata;
    if (req.re) begin
      raddr_q <= req.raddr;
    end
  end

  // unwritten buckets read as zero
  assign rdata = fwd_hit ? fwd_data : (valid[raddr_q] ? ram_q : '0);

endmodule

@@ hdl/counting_sort_keyed_records.sv @@
// ----------------------------------------------------------------------------
// counting_sort_keyed_records
// stable counting sort of keyed records held in on-chip memories
// ----------------------------------------------------------------------------
// channel   direction  handshake                      fields
// input     in         start && !busy                 key, payload, last_record
// result    out        result_valid (one cycle)       sorted_key, sorted_payload,
//                                                     end_of_set, overflow
//
// a record is taken whenever start is high and busy is low; the record ram write port sets the pace
// after the last record: running sums over all buckets through the
// histogram ram, placement of the records in reverse order, then emission
// busy stays high from the cycle after the last record until emission ends
// results come one per cycle and cannot be held off
// synchronous reset clears the control state and the histogram valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module counting_sort_keyed_records
  import csk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_W-1:0]      key,
  input  logic [PAY_PORT_W-1:0] payload,
  input  logic                  last_record,
  output logic                  result_valid,
  output logic [KEY_W-1:0]      sorted_key,
  output logic [PAY_PORT_W-1:0] sorted_payload,
  output logic                  end_of_set,
  output logic                  overflow
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic              ld_valid;
  logic [BKT_W-1:0]  ld_key;
  logic [BKT_W:0]    step;
  logic              s_valid;
  logic [BKT_W-1:0]  s_addr;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W-1:0]  p_cnt;
  logic              p1_valid;
  logic              p2_valid;
  logic [REC_W-1:0]  p2_rec;
  logic [BKT_W-1:0]  p2_key;
  logic [CNT_W-1:0]  em_cnt;
  logic              e1_valid;
  logic              e1_last;

  logic              accept;
  logic              keep_rec;
  logic              sum_issue;
  logic              pl_issue;
  logic              em_issue;
  logic              sum_done;
  logic              place_done;
  logic              emit_done;
  logic [CNT_W-1:0]  acc_new;
  logic [CNT_W-1:0]  pos;
  logic [KEY_W-1:0]  rec_key;
  logic [REC_W-1:0]  rec_rdata;
  logic [REC_W-1:0]  srt_rdata;
  logic [CNT_W-1:0]  hist_rdata;
  hist_req_t         hist_req;

  assign busy      = (state != ST_LOAD);
  assign accept    = start && !busy;
  assign keep_rec  = accept && (count < CNT_W'(MAX_RECORDS)) && (32'(key) < KEY_BUCKETS);
  assign sum_issue = (state == ST_SUM) && (step < (BKT_W + 1)'(KEY_BUCKETS));
  assign pl_issue  = (state == ST_PLACE) && (p_cnt != '0);
  assign em_issue  = (state == ST_EMIT) && (em_cnt < count);
  assign sum_done   = (step == (BKT_W + 1)'(KEY_BUCKETS)) && !s_valid;
  assign place_done = (p_cnt == '0) && !p1_valid && !p2_valid;
  assign emit_done  = (em_cnt == count) && !e1_valid;
  assign acc_new   = acc + hist_rdata;
  assign pos       = hist_rdata - CNT_W'(1);
  assign rec_key   = rec_rdata[REC_W-1 -: KEY_W];

  // histogram port: load increment, running sum, placement decrement
  always_comb begin
    hist_req.re    = accept || sum_issue || p1_valid;
    hist_req.raddr = accept ? BKT_W'(key) :
                     (sum_issue ? step[BKT_W-1:0] : BKT_W'(rec_key));
    hist_req.we    = ld_valid || s_valid || p2_valid;
    hist_req.waddr = ld_valid ? ld_key : (s_valid ? s_addr : p2_key);
    hist_req.wdata = ld_valid ? (hist_rdata + CNT_W'(1)) : (s_valid ? acc_new : pos);
    hist_req.clear = (state == ST_EMIT) && emit_done;
  end

  csk_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .req   (hist_req),
    .rdata (hist_rdata)
  );

  csk_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (keep_rec),
    .waddr (count[REC_AW-1:0]),
    .wdata ({key, payload[PAYLOAD_WIDTH-1:0]}),
    .re    (pl_issue),
    .raddr (REC_AW'(p_cnt - CNT_W'(1))),
    .rdata (rec_rdata)
  );

  csk_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_srt_ram (
    .clk   (clk),
    .we    (p2_valid),
    .waddr (pos[REC_AW-1:0]),
    .wdata (p2_rec),
    .re    (em_issue),
    .raddr (em_cnt[REC_AW-1:0]),
    .rdata (srt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last_record) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (place_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      ld_valid <= 1'b0;
      step     <= '0;
      s_valid  <= 1'b0;
      acc      <= '0;
      p_cnt    <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      em_cnt   <= '0;
      e1_valid <= 1'b0;
      e1_last  <= 1'b0;
    end else begin
      ld_valid <= keep_rec;
      if (keep_rec) begin
        count <= count + CNT_W'(1);
      end
      if (accept && !keep_rec) begin
        dropped <= 1'b1;
      end

      s_valid <= sum_issue;
      if (sum_issue) begin
        step <= step + (BKT_W + 1)'(1);
      end
      if (s_valid) begin
        acc <= acc_new;
      end

      p1_valid <= pl_issue;
      p2_valid <= p1_valid;
      if (pl_issue) begin
        p_cnt <= p_cnt - CNT_W'(1);
      end
      if (state == ST_SUM && sum_done) begin
        p_cnt <= count;
      end

      e1_valid <= em_issue;
      if (em_issue) begin
        em_cnt  <= em_cnt + CNT_W'(1);
        e1_last <= (em_cnt + CNT_W'(1)) == count;
      end
      if (state == ST_PLACE && place_done) begin
        em_cnt <= '0;
      end

      // end of set
      if (hist_req.clear) begin
        count   <= '0;
        dropped <= 1'b0;
        step    <= '0;
        acc     <= '0;
      end
    end
    ld_key <= BKT_W'(key);
    s_addr <= step[BKT_W-1:0];
    if (p1_valid) begin
      p2_rec <= rec_rdata;
      p2_key <= BKT_W'(rec_key);
    end
  end

  assign result_valid   = e1_valid;
  assign sorted_key     = srt_rdata[REC_W-1 -: KEY_W];
  assign sorted_payload = PAY_PORT_W'(srt_rdata[PAYLOAD_WIDTH-1:0]);
  assign end_of_set     = e1_valid && e1_last;
  assign overflow       = dropped;

  `CSK_ASSERT(a_result_in_emit, clk, rst, result_valid |-> (state == ST_EMIT))
  `CSK_ASSERT(a_eos_with_strobe, clk, rst, end_of_set |-> result_valid)
  `CSK_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_RECORDS))
  `CSK_ASSERT(a_place_nonzero, clk, rst, (state == ST_PLACE && p2_valid) |-> (hist_rdata != '0))

endmodule
